[rtl/dps_pkg.sv]
// ----------------------------------------------------------------------------
// Decremental pacing stimulus package
// Widths, defaults and configuration register indexes shared by the block
// and its channel interfaces.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int INDEX_BITS_DEF = 16;

  localparam int AMP_BITS       = 16;
  localparam int PERIOD_BITS    = 32;
  localparam int CYCLES_BITS    = 16;
  localparam int LIMIT_BITS     = 16;
  localparam int SUM_BITS       = 64;
  localparam int BITPOS_BITS    = $clog2(PERIOD_BITS);

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PULSE_AMPLITUDE  = 3'd0,
    CFG_PULSE_OFFSET     = 3'd1,
    CFG_PULSE_LENGTH     = 3'd2,
    CFG_FIRST_PERIOD     = 3'd3,
    CFG_LAST_PERIOD      = 3'd4,
    CFG_PERIOD_DECREMENT = 3'd5,
    CFG_CYCLES_PER_STAGE = 3'd6,
    CFG_STIMULATED_LIMIT = 3'd7
  } cfg_reg_t;

endpackage

[rtl/dps_ifs.sv]
// ----------------------------------------------------------------------------
// Decremental pacing stimulus channels
// Valid/ready interfaces for the request, response and configuration words.
// ----------------------------------------------------------------------------
interface dps_req_if #(
  parameter int INDEX_BITS = dps_pkg::INDEX_BITS_DEF,
  parameter int TIME_BITS  = dps_pkg::TIME_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] cell_index;
  logic [TIME_BITS-1:0]  time_tick;

  modport source (output valid, cell_index, time_tick, input ready);
  modport sink   (input valid, cell_index, time_tick, output ready);
endinterface

interface dps_rsp_if;
  import dps_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [AMP_BITS-1:0] stim_out;

  modport source (output valid, stim_out, input ready);
  modport sink   (input valid, stim_out, output ready);
endinterface

interface dps_cfg_if;
  import dps_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/decremental_pacing_stimulus.sv]
// ----------------------------------------------------------------------------
// Decremental pacing stimulus
// Returns the stimulus current of one cable cell at one time tick, with a
// pacing period that shrinks stage by stage down to a final period.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries a cell index and a time tick; the response
// channel returns one signed stimulus word per request. The configuration
// channel is always ready and writes one register per word; write it only
// while no request is in flight.
// A request runs through a fixed sequence around one shared restoring
// divider (one quotient bit per cycle) and one shared 64-bit adder: the
// final stage number, the time divided by the beats per stage, a greedy
// bit-by-bit search over the 32 bits of the stage number (period, square,
// linear and compare steps per bit, only the first when the candidate is
// past the final stage), one multiply, the phase modulo and the pulse
// compare. A cell above the limit skips all of these and goes straight
// to the done state. Requests are taken one at a time; a new request is
// accepted while the previous response still waits in the output
// register, and a stalled receiver holds the block only when the next
// response is ready.
// Reset restores the register defaults and empties the output.
// ----------------------------------------------------------------------------
module decremental_pacing_stimulus #(
  parameter int TIME_BITS  = dps_pkg::TIME_BITS_DEF,
  parameter int INDEX_BITS = dps_pkg::INDEX_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  dps_cfg_if.sink   cfg,
  dps_req_if.sink   req,
  dps_rsp_if.source rsp
);
  import dps_pkg::*;

  localparam int DW    = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;
  localparam int CW    = DW + 1;
  localparam int IW    = (INDEX_BITS > LIMIT_BITS) ? INDEX_BITS : LIMIT_BITS;
  localparam int CNT_W = $clog2(DW);
  localparam int PW    = TIME_BITS + CYCLES_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_LDIV, S_QDIV, S_SEARCH, S_MULT, S_PHASE, S_MDIV, S_CMP, S_DONE
  } state_t;

  typedef enum logic [1:0] {ST_PER, ST_SQR, ST_LIN, ST_CMP} srch_step_t;

  // Configuration registers
  logic signed [AMP_BITS-1:0] pulse_amplitude;
  logic [PERIOD_BITS-1:0]     pulse_offset;
  logic [PERIOD_BITS-1:0]     pulse_length;
  logic [PERIOD_BITS-1:0]     first_period;
  logic [PERIOD_BITS-1:0]     last_period;
  logic [PERIOD_BITS-1:0]     period_decrement;
  logic [CYCLES_BITS-1:0]     cycles_per_stage;
  logic [LIMIT_BITS-1:0]      stimulated_limit;

  state_t                     state;
  srch_step_t                 step;
  logic [TIME_BITS-1:0]       t_reg;
  logic [PERIOD_BITS-1:0]     last_stage;
  logic [SUM_BITS-1:0]        q;
  logic [PERIOD_BITS-1:0]     lo;
  logic [SUM_BITS-1:0]        sum;
  logic [SUM_BITS-1:0]        acc;
  logic [PERIOD_BITS-1:0]     per;
  logic [BITPOS_BITS-1:0]     bitpos;
  logic [TIME_BITS-1:0]       start_t;
  logic [TIME_BITS-1:0]       phase;
  logic signed [AMP_BITS-1:0] res;
  logic signed [AMP_BITS-1:0] stim;
  logic                       rsp_valid;

  // Shared restoring divider
  logic [PERIOD_BITS:0]       dv_rem;
  logic [DW-1:0]              dv_quo;
  logic [PERIOD_BITS-1:0]     dv_den;
  logic [CNT_W-1:0]           dv_cnt;
  logic [PERIOD_BITS:0]       dv_sh;
  logic                       dv_ge;
  logic [PERIOD_BITS:0]       dv_rem_next;
  logic [DW-1:0]              dv_quo_next;
  logic                       dv_last;

  // Search datapath
  logic [PERIOD_BITS-1:0]     cand;
  logic [BITPOS_BITS:0]       sh_sq;
  logic [BITPOS_BITS-1:0]     sh_lin;
  logic [SUM_BITS-1:0]        dec_ext;
  logic [SUM_BITS-1:0]        dec_shift;
  logic [SUM_BITS-1:0]        au_a;
  logic [SUM_BITS-1:0]        au_b;
  logic                       au_sub;
  logic [SUM_BITS-1:0]        au_y;
  logic                       search_adv;
  logic [PW-1:0]              prod_full;
  logic [TIME_BITS-1:0]       phase_raw;
  logic [CW-1:0]              phase_ext;
  logic [CW-1:0]              pulse_end;
  logic                       pulse_on;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.stim_out = stim;

  always_comb begin
    dv_sh       = {dv_rem[PERIOD_BITS-1:0], dv_quo[DW-1]};
    dv_ge       = (dv_sh >= {1'b0, dv_den});
    dv_rem_next = dv_ge ? (dv_sh - {1'b0, dv_den}) : dv_sh;
    dv_quo_next = {dv_quo[DW-2:0], dv_ge};
    dv_last     = (dv_cnt == CNT_W'(DW - 1));
  end

  // The block sum of 2^b stages from the current one is
  // per*2^b - D*(2^(2b-1) - 2^(b-1)); it is built in three adder passes.
  always_comb begin
    cand      = lo | (PERIOD_BITS'(1) << bitpos);
    sh_sq     = {bitpos, 1'b0} - (BITPOS_BITS + 1)'(1);
    sh_lin    = bitpos - BITPOS_BITS'(1);
    dec_ext   = SUM_BITS'(period_decrement);
    dec_shift = dec_ext << bitpos;
    au_a      = acc;
    au_b      = '0;
    au_sub    = 1'b0;
    unique case (step)
      ST_PER: begin
        au_a = sum;
        au_b = SUM_BITS'(per) << bitpos;
      end
      ST_SQR: begin
        au_b   = (bitpos == '0) ? '0 : (dec_ext << sh_sq);
        au_sub = 1'b1;
      end
      ST_LIN: begin
        au_b = (bitpos == '0) ? '0 : (dec_ext << sh_lin);
      end
      ST_CMP: begin
        au_b = '0;
      end
    endcase
    au_y       = au_sub ? (au_a - au_b) : (au_a + au_b);
    search_adv = (step == ST_CMP) || ((step == ST_PER) && (cand > last_stage));
  end

  always_comb begin
    prod_full = PW'(sum[TIME_BITS-1:0]) * PW'(cycles_per_stage);
    phase_raw = t_reg - start_t;
    phase_ext = CW'(phase);
    pulse_end = CW'(pulse_offset) + CW'(pulse_length);
    pulse_on  = (phase_ext >= CW'(pulse_offset)) && (phase_ext <= pulse_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      step             <= ST_PER;
      rsp_valid        <= 1'b0;
      pulse_amplitude  <= '0;
      pulse_offset     <= '0;
      pulse_length     <= '0;
      first_period     <= PERIOD_BITS'(1);
      last_period      <= PERIOD_BITS'(1);
      period_decrement <= PERIOD_BITS'(1);
      cycles_per_stage <= CYCLES_BITS'(1);
      stimulated_limit <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.index))
          CFG_PULSE_AMPLITUDE:  pulse_amplitude  <= signed'(cfg.data[AMP_BITS-1:0]);
          CFG_PULSE_OFFSET:     pulse_offset     <= cfg.data[PERIOD_BITS-1:0];
          CFG_PULSE_LENGTH:     pulse_length     <= cfg.data[PERIOD_BITS-1:0];
          CFG_FIRST_PERIOD:     first_period     <= cfg.data[PERIOD_BITS-1:0];
          CFG_LAST_PERIOD:      last_period      <= cfg.data[PERIOD_BITS-1:0];
          CFG_PERIOD_DECREMENT: period_decrement <= cfg.data[PERIOD_BITS-1:0];
          CFG_CYCLES_PER_STAGE: cycles_per_stage <= cfg.data[CYCLES_BITS-1:0];
          CFG_STIMULATED_LIMIT: stimulated_limit <= cfg.data[LIMIT_BITS-1:0];
        endcase
      end

      // In the done state the output register is reloaded instead.
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            t_reg <= req.time_tick;
            if (IW'(req.cell_index) > IW'(stimulated_limit)) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              // When no stage can follow the first, divide zero by one.
              dv_rem <= '0;
              dv_cnt <= '0;
              if ((first_period >= last_period) && (period_decrement != '0)) begin
                dv_quo <= DW'(first_period - last_period);
                dv_den <= period_decrement;
              end else begin
                dv_quo <= '0;
                dv_den <= PERIOD_BITS'(1);
              end
              state <= S_LDIV;
            end
          end
        end
        S_LDIV: begin
          if (dv_last) begin
            last_stage <= dv_quo_next[PERIOD_BITS-1:0];
            dv_rem     <= '0;
            dv_cnt     <= '0;
            dv_quo     <= DW'(t_reg);
            dv_den     <= (cycles_per_stage == '0) ? PERIOD_BITS'(1)
                                                   : PERIOD_BITS'(cycles_per_stage);
            state      <= S_QDIV;
          end else begin
            dv_rem <= dv_rem_next;
            dv_quo <= dv_quo_next;
            dv_cnt <= dv_cnt + CNT_W'(1);
          end
        end
        S_QDIV: begin
          if (dv_last) begin
            // With no beats per stage every stage starts at time zero.
            q      <= (cycles_per_stage == '0) ? '1 : SUM_BITS'(dv_quo_next);
            lo     <= '0;
            sum    <= '0;
            per    <= first_period;
            bitpos <= '1;
            step   <= ST_PER;
            state  <= S_SEARCH;
          end else begin
            dv_rem <= dv_rem_next;
            dv_quo <= dv_quo_next;
            dv_cnt <= dv_cnt + CNT_W'(1);
          end
        end
        S_SEARCH: begin
          unique case (step)
            ST_PER: begin
              if (!search_adv) begin
                acc  <= au_y;
                step <= ST_SQR;
              end
            end
            ST_SQR: begin
              acc  <= au_y;
              step <= ST_LIN;
            end
            ST_LIN: begin
              acc  <= au_y;
              step <= ST_CMP;
            end
            ST_CMP: begin
              step <= ST_PER;
              if (acc <= q) begin
                sum <= acc;
                lo  <= cand;
                per <= per - dec_shift[PERIOD_BITS-1:0];
              end
            end
          endcase
          if (search_adv) begin
            if (bitpos == '0) begin
              state <= S_MULT;
            end else begin
              bitpos <= bitpos - BITPOS_BITS'(1);
            end
          end
        end
        S_MULT: begin
          start_t <= prod_full[TIME_BITS-1:0];
          state   <= S_PHASE;
        end
        S_PHASE: begin
          phase  <= phase_raw;
          dv_rem <= '0;
          dv_cnt <= '0;
          dv_quo <= DW'(phase_raw);
          dv_den <= (per == '0) ? PERIOD_BITS'(1) : per;
          state  <= S_MDIV;
        end
        S_MDIV: begin
          if (dv_last) begin
            // A zero period leaves the time since the stage start unwrapped.
            if (per != '0) begin
              phase <= TIME_BITS'(dv_rem_next);
            end
            state <= S_CMP;
          end else begin
            dv_rem <= dv_rem_next;
            dv_quo <= dv_quo_next;
            dv_cnt <= dv_cnt + CNT_W'(1);
          end
        end
        S_CMP: begin
          res   <= pulse_on ? pulse_amplitude : '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            stim      <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_lo_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (lo <= last_stage))
    else $error("stage search went past the final stage");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_LDIV || state == S_QDIV || state == S_MDIV) |-> (dv_den != '0))
    else $error("divider running with a zero divisor");

  a_rsp_drain: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && state != S_DONE) |=> !rsp.valid)
    else $error("response word repeated after it was taken");

endmodule

[sim/pacing_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pacing stimulus checker
// Watches the configuration, request and response channels of the pacing
// stimulus block, keeps its own copy of the registers, works out the stimulus
// word due for every accepted request and compares the responses in order.
// ----------------------------------------------------------------------------
module pacing_checker (
  input  logic clk,
  input  logic rst,
  dps_cfg_if   cfg,
  dps_req_if   req,
  dps_rsp_if   rsp,
  output int   fail_count,
  output int   awaiting
);
  import dps_pkg::*;

  localparam logic [SUM_BITS-1:0] ONSET_CEILING = 64'h8000_0000_0000_0000;

  typedef struct {
    logic signed [AMP_BITS-1:0]     stim;
    logic [INDEX_BITS_DEF-1:0]      cell_id;
    logic [TIME_BITS_DEF-1:0]       tick;
  } stim_entry_t;

  logic signed [AMP_BITS-1:0] pulse_amp;
  logic [PERIOD_BITS-1:0]     pulse_start;
  logic [PERIOD_BITS-1:0]     pulse_len;
  logic [PERIOD_BITS-1:0]     period_first;
  logic [PERIOD_BITS-1:0]     period_last;
  logic [PERIOD_BITS-1:0]     period_shrink;
  logic [CYCLES_BITS-1:0]     beats_per_stage;
  logic [LIMIT_BITS-1:0]      paced_limit;

  stim_entry_t expected_stim[$];
  int          mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] stimulus mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Tick at which stage j begins: beats_per_stage times the sum of the
  // periods of all earlier stages, clipped well above any reachable tick.
  function automatic logic [SUM_BITS-1:0] stage_onset(input logic [SUM_BITS-1:0] j);
    logic [SUM_BITS-1:0]   tail;
    logic [SUM_BITS-1:0]   both_ends;
    logic [SUM_BITS-1:0]   series;
    logic [2*SUM_BITS-1:0] product;
    if (j == 0) begin
      return '0;
    end
    tail      = 64'(period_first) - (j - 1) * 64'(period_shrink);
    both_ends = 64'(period_first) + tail;
    series    = j[0] ? j * (both_ends >> 1) : (j >> 1) * both_ends;
    product   = 128'(series) * 128'(beats_per_stage);
    return (product > 128'(ONSET_CEILING)) ? ONSET_CEILING : product[SUM_BITS-1:0];
  endfunction

  function automatic logic signed [AMP_BITS-1:0] predict_stim(
    input logic [INDEX_BITS_DEF-1:0] cell_id,
    input logic [TIME_BITS_DEF-1:0]  tick
  );
    logic [SUM_BITS-1:0] final_stage;
    logic [SUM_BITS-1:0] stage;
    logic [SUM_BITS-1:0] trial;
    logic [SUM_BITS-1:0] onset;
    logic [SUM_BITS-1:0] period;
    logic [SUM_BITS-1:0] phase;
    if (cell_id > paced_limit) begin
      return '0;
    end
    final_stage = '0;
    if (period_first >= period_last && period_shrink != 0) begin
      final_stage = 64'((period_first - period_last) / period_shrink);
    end
    // Onsets never decrease with the stage number, so the latest stage that
    // has begun can be built up one bit at a time from the top.
    stage = '0;
    for (int b = PERIOD_BITS - 1; b >= 0; b--) begin
      trial = stage | (64'd1 << b);
      if (trial <= final_stage && stage_onset(trial) <= 64'(tick)) begin
        stage = trial;
      end
    end
    onset  = stage_onset(stage);
    period = 64'(period_first) - stage * 64'(period_shrink);
    phase  = 64'(tick) - onset;
    if (period != 0) begin
      phase = phase % period;
    end
    if (phase >= 64'(pulse_start) && phase <= 64'(pulse_start) + 64'(pulse_len)) begin
      return pulse_amp;
    end
    return '0;
  endfunction

  always @(posedge clk) begin
    stim_entry_t oldest;
    if (rst) begin
      pulse_amp       <= '0;
      pulse_start     <= '0;
      pulse_len       <= '0;
      period_first    <= 32'd1;
      period_last     <= 32'd1;
      period_shrink   <= 32'd1;
      beats_per_stage <= 16'd1;
      paced_limit     <= '0;
      expected_stim.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_PULSE_AMPLITUDE:  pulse_amp       <= cfg.data[AMP_BITS-1:0];
          CFG_PULSE_OFFSET:     pulse_start     <= cfg.data;
          CFG_PULSE_LENGTH:     pulse_len       <= cfg.data;
          CFG_FIRST_PERIOD:     period_first    <= cfg.data;
          CFG_LAST_PERIOD:      period_last     <= cfg.data;
          CFG_PERIOD_DECREMENT: period_shrink   <= cfg.data;
          CFG_CYCLES_PER_STAGE: beats_per_stage <= cfg.data[CYCLES_BITS-1:0];
          CFG_STIMULATED_LIMIT: paced_limit     <= cfg.data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_stim.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", rsp.stim_out));
        end else begin
          oldest = expected_stim.pop_front();
          if (rsp.stim_out !== oldest.stim) begin
            report_mismatch($sformatf("cell %0d tick %0d: got %0d, want %0d",
                                      oldest.cell_id, oldest.tick, rsp.stim_out,
                                      oldest.stim));
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_stim.push_back('{predict_stim(req.cell_index, req.time_tick),
                                  req.cell_index, req.time_tick});
      end
    end
    fail_count <= mismatches;
    awaiting   <= expected_stim.size();
  end

endmodule

[sim/tb_decremental_pacing_stimulus.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pacing stimulus testbench
// Loads a series of pacing settings, from special cases to random and extreme
// ones, and offers cell and tick requests aimed at stage and pulse edges,
// with random idling on both sides. A checker beside the block predicts and
// compares every response word.
// ----------------------------------------------------------------------------
module tb_decremental_pacing_stimulus;
  import dps_pkg::*;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [AMP_BITS-1:0]    amp;
    logic [PERIOD_BITS-1:0] offs;
    logic [PERIOD_BITS-1:0] len;
    logic [PERIOD_BITS-1:0] first;
    logic [PERIOD_BITS-1:0] last;
    logic [PERIOD_BITS-1:0] dec;
    logic [CYCLES_BITS-1:0] cps;
    logic [LIMIT_BITS-1:0]  lim;
  } pacing_set_t;

  localparam int          RANDOM_PHASES   = 12;
  localparam int          WORDS_PER_PHASE = 80;
  localparam int          HOLD_CYCLES     = 600;
  localparam int          SETTLE_CYCLES   = 250;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;

  logic        clk;
  logic        rst;
  idle_mode_t  mode = IDLE_NONE;
  bit          hold_request = 1'b0;
  int          fail_count;
  int          awaiting;
  int unsigned cycle_count = 0;
  pacing_set_t cur;

  dps_cfg_if cfg_ch ();
  dps_req_if req_ch ();
  dps_rsp_if rsp_ch ();

  decremental_pacing_stimulus DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pacing_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit sender_pauses();
    case (mode)
      IDLE_SEND: return $urandom_range(0, 99) < 51;
      IDLE_BOTH: return $urandom_range(0, 99) < 24;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (mode)
      IDLE_RECV: return $urandom_range(0, 99) < 51;
      IDLE_BOTH: return $urandom_range(0, 99) < 24;
      default:   return 1'b0;
    endcase
  endfunction

  // Receiver: random stalls, and on request one long hold-off of its own.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        rsp_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_request = 1'b0;
      end
      rsp_ch.ready <= !receiver_stalls();
    end
  end

  function automatic pacing_set_t make_set(
    input logic [AMP_BITS-1:0]    amp,
    input logic [PERIOD_BITS-1:0] offs, len, first, last, dec,
    input logic [CYCLES_BITS-1:0] cps,
    input logic [LIMIT_BITS-1:0]  lim
  );
    pacing_set_t s;
    s.amp   = amp;
    s.offs  = offs;
    s.len   = len;
    s.first = first;
    s.last  = last;
    s.dec   = dec;
    s.cps   = cps;
    s.lim   = lim;
    return s;
  endfunction

  function automatic pacing_set_t random_set();
    pacing_set_t s;
    int unsigned style;
    style = $urandom_range(0, 5);
    s.amp = 16'($urandom());
    case ($urandom_range(0, 4))
      0:       s.lim = '0;
      1:       s.lim = '1;
      2:       s.lim = 16'($urandom_range(0, 50));
      default: s.lim = 16'($urandom());
    endcase
    s.first = $urandom_range(1, 64);
    s.last  = $urandom_range(1, s.first);
    s.dec   = $urandom_range(1, 8);
    s.cps   = 16'($urandom_range(1, 6));
    s.offs  = $urandom_range(0, s.first);
    s.len   = $urandom_range(0, s.first / 2);
    case (style)
      2: begin
        s.first = $urandom_range(1, 5000);
        s.last  = $urandom_range(1, s.first);
        s.dec   = $urandom_range(1, 300);
        s.cps   = 16'($urandom_range(1, 50));
        s.offs  = $urandom_range(0, s.first);
        s.len   = $urandom_range(0, s.first);
      end
      3: begin
        s.first = $urandom();
        s.last  = $urandom();
        s.dec   = $urandom();
        s.cps   = 16'($urandom());
        s.offs  = $urandom();
        s.len   = $urandom();
      end
      4: begin
        case ($urandom_range(0, 4))
          0: s.cps = '0;
          1: s.dec = '0;
          2: s.last = s.first + $urandom_range(1, 50);
          3: s.last = '0;
          default: begin
            s.first = '0;
            s.last  = '0;
          end
        endcase
      end
      5: begin
        if ($urandom_range(0, 1)) begin
          s.first = '1;
          s.last  = $urandom_range(1, 4);
          s.dec   = $urandom_range(1, 3);
          s.cps   = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
        end else begin
          // Many short stages packed into the reachable range of ticks.
          s.first = $urandom_range(2000, 200000);
          s.last  = $urandom_range(1, 100);
          s.dec   = $urandom_range(1, 20);
          s.cps   = 16'($urandom_range(1, 3));
        end
        s.offs = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 1000));
        s.len  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 100000));
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [INDEX_BITS_DEF-1:0] pick_cell();
    case ($urandom_range(0, 9))
      6:       return cur.lim;
      7:       return cur.lim + 16'd1;
      8, 9:    return 16'($urandom());
      default: return 16'($urandom_range(0, cur.lim));
    endcase
  endfunction

  // Most ticks land on a chosen beat of a chosen stage, often right at an
  // edge of the pulse; the stage onsets are walked up from tick zero.
  function automatic logic [TIME_BITS_DEF-1:0] pick_tick();
    logic [SUM_BITS-1:0] base;
    logic [SUM_BITS-1:0] per;
    logic [SUM_BITS-1:0] phase;
    logic [SUM_BITS-1:0] tick;
    int unsigned         sel;
    int unsigned         reach;
    int unsigned         stage;
    int unsigned         beats;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      return $urandom();
    end
    reach = 0;
    if (cur.first >= cur.last && cur.dec != 0) begin
      reach = (cur.first - cur.last) / cur.dec;
    end
    if (reach > 40) begin
      reach = 40;
    end
    stage = $urandom_range(0, reach);
    base  = '0;
    per   = 64'(cur.first);
    for (int s = 0; s < stage; s++) begin
      base += per * 64'(cur.cps);
      per  -= 64'(cur.dec);
    end
    beats = $urandom_range(0, 32'(cur.cps) + 1);
    if (sel < 4) begin
      phase = (per == 0) ? 64'($urandom_range(0, 1000)) : 64'($urandom()) % per;
    end else begin
      case ($urandom_range(0, 3))
        0:       phase = 64'(cur.offs) - 64'd1;
        1:       phase = 64'(cur.offs);
        2:       phase = 64'(cur.offs) + 64'(cur.len);
        default: phase = 64'(cur.offs) + 64'(cur.len) + 64'd1;
      endcase
    end
    tick = base + 64'(beats) * per + phase;
    return tick[TIME_BITS_DEF-1:0];
  endfunction

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_pacing(input pacing_set_t s);
    write_register(CFG_PULSE_AMPLITUDE, {{16{s.amp[AMP_BITS-1]}}, s.amp});
    write_register(CFG_PULSE_OFFSET, s.offs);
    write_register(CFG_PULSE_LENGTH, s.len);
    write_register(CFG_FIRST_PERIOD, s.first);
    write_register(CFG_LAST_PERIOD, s.last);
    write_register(CFG_PERIOD_DECREMENT, s.dec);
    write_register(CFG_CYCLES_PER_STAGE, 32'(s.cps));
    write_register(CFG_STIMULATED_LIMIT, 32'(s.lim));
    cfg_ch.valid <= 1'b0;
    cur = s;
  endtask

  task automatic offer_request(input logic [INDEX_BITS_DEF-1:0] cell_id,
                               input logic [TIME_BITS_DEF-1:0] tick);
    while (sender_pauses()) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cell_index <= cell_id;
    req_ch.time_tick  <= tick;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted word has come back.
  task automatic settle_block();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.cell_index <= '0;
    req_ch.time_tick  <= '0;
    cur = make_set(16'h0000, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 16'd1, 16'd0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Register defaults straight after reset.
    offer_request(16'd0, 32'd0);
    offer_request(16'hFFFF, 32'hFFFF_FFFF);
    settle_block();

    // Step lands on the final period; cells either side of the limit.
    load_pacing(make_set(16'h8000, 32'd0, 32'd0, 32'd10, 32'd4, 32'd3, 16'd2, 16'd100));
    offer_request(16'd100, 32'd20);
    offer_request(16'd101, 32'd20);
    offer_request(16'd0, 32'd34);
    offer_request(16'd5, 32'd35);
    settle_block();

    // Step overshoots the final period, so the last period tried holds.
    load_pacing(make_set(16'h7FFF, 32'd2, 32'd3, 32'd20, 32'd5, 32'd4, 16'd3, 16'hFFFF));
    offer_request(16'hFFFF, 32'd174);
    offer_request(16'hFFFF, 32'd172);
    offer_request(16'd1, 32'd62);
    settle_block();

    // First period below the final one.
    load_pacing(make_set(16'd1234, 32'd1, 32'd1, 32'd5, 32'd9, 32'd2, 16'd4, 16'd0));
    offer_request(16'd0, 32'd6);
    offer_request(16'd0, 32'hFFFF_FFFF);
    settle_block();

    // No decrement at all.
    load_pacing(make_set(16'hFFFF, 32'd0, 32'd2, 32'd7, 32'd3, 32'd0, 16'd1, 16'd10));
    offer_request(16'd3, 32'd1000);
    offer_request(16'd3, 32'd1001);
    settle_block();

    // Empty stages: the final period applies from tick zero.
    load_pacing(make_set(16'd77, 32'd1, 32'd0, 32'd12, 32'd2, 32'd5, 16'd0, 16'd10));
    offer_request(16'd0, 32'd3);
    offer_request(16'd0, 32'd4);
    settle_block();

    // Period shrinks to zero, after which the phase no longer wraps.
    load_pacing(make_set(16'd300, 32'd5, 32'd10, 32'd9, 32'd0, 32'd3, 16'd1, 16'd10));
    offer_request(16'd2, 32'd23);
    offer_request(16'd2, 32'd40);
    settle_block();
    load_pacing(make_set(16'd300, 32'd5, 32'd10, 32'd0, 32'd0, 32'd1, 16'd1, 16'd10));
    offer_request(16'd0, 32'd15);
    offer_request(16'd0, 32'd16);
    settle_block();

    // Pulse end past the top of the 32-bit range.
    load_pacing(make_set(16'd5, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1,
                         16'hFFFF, 16'hFFFF));
    offer_request(16'd0, 32'hFFFF_FFF0);
    offer_request(16'd0, 32'hFFFF_FFFE);
    offer_request(16'd0, 32'd100);
    settle_block();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mode = idle_mode_t'(ph % 4);
      load_pacing(random_set());
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // Hold the receiver off while requests keep coming, so the block
        // backs up to its input.
        if (ph == 0 && i == 30) begin
          hold_request = 1'b1;
        end
        if (ph == 1 && i == 40) begin
          settle_block();
        end
        offer_request(pick_cell(), pick_tick());
      end
      settle_block();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dps_pkg.sv
rtl/dps_ifs.sv
rtl/decremental_pacing_stimulus.sv
sim/pacing_checker.sv
sim/tb_decremental_pacing_stimulus.sv
